// ----- design/tmcw_pkg.sv -----
package tmcw_pkg;

  // Result field widths.
  localparam int OUT_ADDR_W = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CHAR_W     = 8;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_BS          = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB         = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF          = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR          = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK       = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST  = 8'h7F;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

  typedef enum logic [2:0] {
    K_PRINT,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_IGNORE,
    K_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] character;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } back_state_t;

endpackage

// ----- design/tmcw_if.sv -----
interface tmcw_in_if
  import tmcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output mode, output character, input ready);
  modport sink (input valid, input mode, input character, output ready);
endinterface

interface tmcw_out_if
  import tmcw_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] cursor_offset;
  logic                  cell_written;
  logic [OUT_ADDR_W-1:0] cell_address;
  logic [CELL_W-1:0]     cell_value;
  logic                  scrolled;

  modport source (
    output valid, output cursor_offset, output cell_written,
    output cell_address, output cell_value, output scrolled, input ready
  );
  modport sink (
    input valid, input cursor_offset, input cell_written,
    input cell_address, input cell_value, input scrolled, output ready
  );
endinterface

// ----- design/tmcw_ram.sv -----
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/tmcw_front.sv -----
module tmcw_front
  import tmcw_pkg::*;
(
  tmcw_in_if.sink in_ch,
  input  logic    init_busy,
  input  logic    queue_full,
  output logic    push,
  output cmd_t    push_cmd
);

  logic [CHAR_W-1:0] ch;

  assign ch          = in_ch.character;
  assign in_ch.ready = !queue_full && !init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_cmd.character = ch;
    if (in_ch.mode) begin
      push_cmd.kind = K_CLEAR;
    end else if (ch >= CH_PRINT_FIRST && ch <= CH_PRINT_LAST) begin
      push_cmd.kind = K_PRINT;
    end else begin
      priority case (ch)
        CH_BS:   push_cmd.kind = K_BS;
        CH_TAB:  push_cmd.kind = K_TAB;
        CH_CR:   push_cmd.kind = K_CR;
        CH_LF:   push_cmd.kind = K_LF;
        default: push_cmd.kind = K_IGNORE;
      endcase
    end
  end

endmodule

// ----- design/tmcw_queue.sv -----
module tmcw_queue
  import tmcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/tmcw_back.sv -----
module tmcw_back
  import tmcw_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ATTR_W-1:0] attribute,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              init_busy,
  tmcw_out_if.source        out_ch
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int EXT_W  = (ADDR_W > OUT_ADDR_W) ? ADDR_W : OUT_ADDR_W;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int PH_W   = $clog2(TAB_WIDTH);

  localparam logic [ADDR_W-1:0] COPY_LEN  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;

  logic              res_written_r, res_written_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [CELL_W-1:0] res_value_r, res_value_nxt;
  logic              res_scrolled_r, res_scrolled_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_ADDR_W-1:0] out_offset_r, out_offset_nxt;
  logic                  out_written_r, out_written_nxt;
  logic [OUT_ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [CELL_W-1:0]     out_value_r, out_value_nxt;
  logic                  out_scrolled_r, out_scrolled_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [COLX_W-1:0] col_t;
  logic [ROWX_W-1:0] row_t;
  logic [PH_W-1:0]   ph_t;
  logic [ADDR_W-1:0] cursor_addr;
  logic [EXT_W-1:0]  offset_ext;
  logic [EXT_W-1:0]  addr_ext;
  logic [CELL_W-1:0] blank_cell;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign cursor_addr = ADDR_W'(row_r * COLUMNS) + ADDR_W'(col_r);
  assign offset_ext  = EXT_W'(cursor_addr);
  assign addr_ext    = EXT_W'(res_addr_r);
  assign blank_cell  = {attribute, CH_BLANK};
  assign init_busy   = (state_r == ST_INIT);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_offset = out_offset_r;
  assign out_ch.cell_written  = out_written_r;
  assign out_ch.cell_address  = out_addr_r;
  assign out_ch.cell_value    = out_value_r;
  assign out_ch.scrolled      = out_scrolled_r;

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_r;
    pend_nxt         = 1'b0;
    waddr_nxt        = waddr_r;
    res_written_nxt  = res_written_r;
    res_addr_nxt     = res_addr_r;
    res_value_nxt    = res_value_r;
    res_scrolled_nxt = res_scrolled_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_offset_nxt   = out_offset_r;
    out_written_nxt  = out_written_r;
    out_addr_nxt     = out_addr_r;
    out_value_nxt    = out_value_r;
    out_scrolled_nxt = out_scrolled_r;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = cnt_r;
    ram_wdata        = blank_cell;
    ram_re           = 1'b0;
    ram_raddr        = cnt_r + ROW_STEP;
    col_t            = COLX_W'(col_r);
    row_t            = ROWX_W'(row_r);
    ph_t             = phase_r;

    unique case (state_r)
      ST_INIT: begin
        // Sweep the whole store to blanks after reset.
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_written_nxt  = 1'b0;
        res_addr_nxt     = '0;
        res_value_nxt    = '0;
        res_scrolled_nxt = 1'b0;
        if (cmd_r.kind == K_CLEAR) begin
          col_nxt   = '0;
          row_nxt   = '0;
          phase_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_FILL;
        end else begin
          unique case (cmd_r.kind)
            K_PRINT: begin
              ram_we          = 1'b1;
              ram_waddr       = cursor_addr;
              ram_wdata       = {attribute, cmd_r.character};
              res_written_nxt = 1'b1;
              res_addr_nxt    = cursor_addr;
              res_value_nxt   = {attribute, cmd_r.character};
              col_t           = COLX_W'(col_r) + 1'b1;
              ph_t = (phase_r == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_r + 1'b1;
            end
            K_BS: begin
              if (col_r != '0) begin
                col_t = COLX_W'(col_r) - 1'b1;
                ph_t  = (phase_r == '0) ? PH_W'(TAB_WIDTH - 1) : phase_r - 1'b1;
              end
            end
            K_TAB: begin
              col_t = COLX_W'(col_r) + COLX_W'(TAB_WIDTH) - COLX_W'(phase_r);
              ph_t  = '0;
            end
            K_CR: begin
              col_t = '0;
              ph_t  = '0;
            end
            K_LF: begin
              col_t = '0;
              ph_t  = '0;
              row_t = ROWX_W'(row_r) + 1'b1;
            end
            default: begin
            end
          endcase

          // Line wrap at the right edge.
          if (col_t >= COLX_W'(COLUMNS)) begin
            col_t = '0;
            ph_t  = '0;
            row_t = row_t + 1'b1;
          end

          col_nxt   = COL_W'(col_t);
          phase_nxt = ph_t;
          cnt_nxt   = '0;
          if (row_t >= ROWX_W'(ROWS)) begin
            row_nxt          = ROW_W'(ROWS - 1);
            res_scrolled_nxt = 1'b1;
            state_nxt        = ST_SCROLL;
          end else begin
            row_nxt   = ROW_W'(row_t);
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SCROLL: begin
        // Each cycle reads one row below and writes the previous read back
        // one row up; the read and write addresses never coincide.
        ram_we    = pend_r;
        ram_waddr = waddr_r;
        ram_wdata = ram_rdata;
        if (cnt_r == COPY_LEN) begin
          cnt_nxt   = LAST_ROW0;
          state_nxt = ST_FILL;
        end else begin
          ram_re    = 1'b1;
          pend_nxt  = 1'b1;
          waddr_nxt = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end

      ST_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_offset_nxt   = offset_ext[OUT_ADDR_W-1:0];
          out_written_nxt  = res_written_r;
          out_addr_nxt     = addr_ext[OUT_ADDR_W-1:0];
          out_value_nxt    = res_value_r;
          out_scrolled_nxt = res_scrolled_r;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    waddr_r        <= waddr_nxt;
    res_written_r  <= res_written_nxt;
    res_addr_r     <= res_addr_nxt;
    res_value_r    <= res_value_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    out_offset_r   <= out_offset_nxt;
    out_written_r  <= out_written_nxt;
    out_addr_r     <= out_addr_nxt;
    out_value_r    <= out_value_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

endmodule

// ----- design/text_mode_console_writer.sv -----
// A character or control code passes through the command queue and the back end's idle,
// execute and done states before its output transaction. A scroll copies the screen up a
// row and blanks the last row, a clear blanks it all, both through the single write port
// of the screen memory. A new command is popped only after the last result is handed on,
// and a 4-entry queue absorbs input. Reset: cursor home, attribute 0x07, then a pass blanks
// the screen memory to 0x0720; input is not accepted until it ends, configuration writes are.
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  tmcw_in_if.sink           in_ch,
  tmcw_out_if.source        out_ch
);

  logic [ATTR_W-1:0] attr_r;
  logic              init_busy;
  logic              queue_full;
  logic              queue_empty;
  logic              push;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  tmcw_front u_front (
    .in_ch      (in_ch),
    .init_busy  (init_busy),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tmcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  tmcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attribute (attr_r),
    .q_empty   (queue_empty),
    .q_head    (head_cmd),
    .q_pop     (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

// ----- sim/text_mode_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_mode_console_writer_tb;
  import tmcw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_WIDTH     = 8;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 2100;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] cursor_offset;
    logic                  cell_written;
    logic [OUT_ADDR_W-1:0] cell_address;
    logic [CELL_W-1:0]     cell_value;
    logic                  scrolled;
  } report_t;

  typedef struct {
    logic              mode;
    logic [CHAR_W-1:0] character;
    int                reps;
    bit                known;
    report_t           want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ATTR_W-1:0] cfg_wr_data;

  tmcw_in_if  in_ch ();
  tmcw_out_if out_ch ();

  text_mode_console_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Shadow of the console state that decides every report.
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic [ATTR_W-1:0] cur_attr;

  report_t   cursor_reports[$];
  int        mismatch_count;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        quiet_cycles;
  stim_row_t directed_rows[23];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic report_t console_update(input logic m, input logic [CHAR_W-1:0] c);
    report_t r;
    r = '0;
    if (m) begin
      cur_col = '0;
      cur_row = '0;
    end else begin
      if (c == CH_BS) begin
        if (cur_col != 0) cur_col = cur_col - 7'd1;
      end else if (c == CH_TAB) begin
        cur_col = 7'(cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH));
      end else if (c == CH_CR) begin
        cur_col = '0;
      end else if (c == CH_LF) begin
        cur_col = '0;
        cur_row = cur_row + 5'd1;
      end else if (c >= CH_PRINT_FIRST && c <= CH_PRINT_LAST) begin
        r.cell_written = 1'b1;
        r.cell_address = OUT_ADDR_W'(cur_row * COLUMNS + cur_col);
        r.cell_value   = {cur_attr, c};
        cur_col        = cur_col + 7'd1;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = '0;
        cur_row = cur_row + 5'd1;
      end
      if (cur_row >= ROWS) begin
        cur_row    = 5'(ROWS - 1);
        r.scrolled = 1'b1;
      end
    end
    r.cursor_offset = OUT_ADDR_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  task automatic send_command(input logic m, input logic [CHAR_W-1:0] c,
                              output report_t predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.character <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = console_update(m, c);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cursor_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_attr = value;
  endtask

  // Mostly text with line control, plus ignored bytes and an occasional clear.
  task automatic random_command(output logic m, output logic [CHAR_W-1:0] c);
    int pick;
    pick = $urandom_range(999);
    m = 1'b0;
    if (pick < 8) begin
      m = 1'b1;
      c = CHAR_W'($urandom_range(255));
    end else if (pick < 600) begin
      c = CHAR_W'($urandom_range(CH_PRINT_LAST, CH_PRINT_FIRST));
    end else if (pick < 700) begin
      c = CH_LF;
    end else if (pick < 760) begin
      c = CH_TAB;
    end else if (pick < 810) begin
      c = CH_BS;
    end else if (pick < 850) begin
      c = CH_CR;
    end else if (pick < 900) begin
      c = CHAR_W'($urandom_range(31));
    end else begin
      c = CHAR_W'($urandom_range(255, 128));
    end
  endtask

  task automatic run_random_phase(input int count, input int tx_pct, input int rx_pct,
                                  input logic [ATTR_W-1:0] attr_value);
    logic              m;
    logic [CHAR_W-1:0] c;
    report_t           predicted;
    drain_results();
    write_attribute(attr_value);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      random_command(m, c);
      send_command(m, c, predicted);
      cursor_reports.push_back(predicted);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cursor_reports.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got offset 0x%0h value 0x%0h",
                 $time, out_ch.cursor_offset, out_ch.cell_value);
        mismatch_count++;
      end else begin
        want = cursor_reports.pop_front();
        check_field("cursor_offset", 32'(want.cursor_offset), 32'(out_ch.cursor_offset));
        check_field("cell_written", 32'(want.cell_written), 32'(out_ch.cell_written));
        check_field("cell_address", 32'(want.cell_address), 32'(out_ch.cell_address));
        check_field("cell_value", 32'(want.cell_value), 32'(out_ch.cell_value));
        check_field("scrolled", 32'(want.scrolled), 32'(out_ch.scrolled));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("text_mode_console_writer_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    report_t predicted;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.character <= '0;
    quiet_cycles    = 0;
    mismatch_count  = 0;
    tx_idle_pct     = 20;
    rx_idle_pct     = 76;
    cur_col         = '0;
    cur_row         = '0;
    cur_attr        = RESET_ATTR;

    // Rows with known = 1 carry a report that follows directly from the cursor position
    // left by the rows before them, with the reset attribute.
    directed_rows = '{
      '{1'b0, 8'h41, 1, 1'b1, '{11'd1, 1'b1, 11'd0, 16'h0741, 1'b0}},
      '{1'b0, CH_PRINT_FIRST, 1, 1'b1, '{11'd2, 1'b1, 11'd1, 16'h0720, 1'b0}},
      '{1'b0, CH_PRINT_LAST, 1, 1'b1, '{11'd3, 1'b1, 11'd2, 16'h077F, 1'b0}},
      '{1'b0, 8'h1F, 1, 1'b1, '{11'd3, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, 8'h80, 1, 1'b1, '{11'd3, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, 8'hFF, 1, 1'b1, '{11'd3, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, 8'h00, 1, 1'b1, '{11'd3, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_BS, 1, 1'b1, '{11'd2, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_CR, 1, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_BS, 1, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_TAB, 1, 1'b1, '{11'd8, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_TAB, 1, 1'b1, '{11'd16, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, 8'h78, 1, 1'b0, '0},
      '{1'b0, CH_TAB, 1, 1'b0, '0},
      '{1'b0, CH_LF, 1, 1'b1, '{11'd80, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b1, 8'hFF, 1, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0000, 1'b0}},
      '{1'b0, CH_LF, 24, 1'b0, '0},
      '{1'b0, CH_LF, 1, 1'b0, '0},
      '{1'b0, CH_TAB, 9, 1'b0, '0},
      '{1'b0, 8'h33, 7, 1'b0, '0},
      '{1'b0, 8'h42, 1, 1'b1, '{11'd1920, 1'b1, 11'd1999, 16'h0742, 1'b1}},
      '{1'b0, CH_TAB, 10, 1'b0, '0},
      '{1'b1, 8'h41, 1, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0000, 1'b0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_attribute(RESET_ATTR);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_command(directed_rows[i].mode, directed_rows[i].character, predicted);
        cursor_reports.push_back(directed_rows[i].known ? directed_rows[i].want : predicted);
      end
    end

    run_random_phase(250, 20, 76, 8'hFF);
    run_random_phase(250, 76, 20, 8'h00);
    run_random_phase(140, 0, 0, ATTR_W'($urandom_range(255)));
    run_random_phase(140, 0, 0, ATTR_W'($urandom_range(255)));

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("text_mode_console_writer_tb: clean");
    end else begin
      $display("text_mode_console_writer_tb: errors");
    end
    $finish;
  end

endmodule
